// ----- hw/rtl/euler_angles_to_rotation_matrix_top_macros.svh -----
// Assertion macros used by the top-level RTL
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define E2R_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define E2R_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define E2R_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define E2R_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- hw/rtl/e2r_pkg.sv -----
`default_nettype none
package e2r_pkg;
    localparam int NSTAGE     = 9;
    localparam int LANE_LAST  = 5;
    localparam int MERGE_LAST = NSTAGE - 1;

    typedef logic [NSTAGE-1:0] stage_en_t;
    typedef logic signed [15:0] q14_t;

    localparam logic [30:0] K9 = 31'd172272;
    // Horner coefficients in order of use
    localparam logic [30:0] HORNER_C [4] = '{31'd5026995, 31'd85569306,
                                            31'd693598668, 31'd1686629713};
    localparam logic [14:0] QUARTER = 15'd16384;
    localparam q14_t ONE_Q14 = 16'sd16384;
endpackage
`default_nettype wire

// ----- hw/rtl/e2r_angles_if.sv -----
`default_nettype none
interface e2r_angles_if;
    logic        valid;
    logic        ready;
    logic [15:0] x_axis_angle;
    logic [15:0] y_axis_angle;
    logic [15:0] z_axis_angle;
    modport source (output valid, x_axis_angle, y_axis_angle, z_axis_angle, input ready);
    modport sink (input valid, x_axis_angle, y_axis_angle, z_axis_angle, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/e2r_matrix_if.sv -----
`default_nettype none
interface e2r_matrix_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/euler_angles_to_rotation_matrix_top.sv -----
`default_nettype none
// Euler angles to 3x3 rotation matrix (Rx*Ry*Rz, row-major, Q1.14).
// Fully pipelined: one request per cycle unless all stages are full and the
// output stalls. There are nine register stages. Six sine/cosine
// lanes take six stages: quadrant fold and square, four Horner steps, then
// final scale, cap and sign. Three merge stages then form the matrix product,
// round and saturate. Each stage holds while the next is full and stalled, so
// empty stages still take requests while a result waits at the output.
`include "euler_angles_to_rotation_matrix_top_macros.svh"
module euler_angles_to_rotation_matrix_top (
    input wire logic     clk,
    input wire logic     rst_n,
    e2r_angles_if.sink   ang,
    e2r_matrix_if.source mat
);
    logic [e2r_pkg::NSTAGE-1:0] vld_reg;
    logic [e2r_pkg::NSTAGE-1:0] vld_next;
    e2r_pkg::stage_en_t         en;
    e2r_pkg::q14_t              lane_out [6];
    e2r_pkg::q14_t              m [9];
    logic [15:0]                ang_in [6];

    always_comb
    begin
        en[e2r_pkg::NSTAGE-1] = !vld_reg[e2r_pkg::NSTAGE-1] || mat.ready;
        for (int k = e2r_pkg::NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? ang.valid : vld_reg[0];
        for (int k = 1; k < e2r_pkg::NSTAGE; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
            else
            begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // cosine is the sine a quarter turn on
    assign ang_in[0] = ang.x_axis_angle;
    assign ang_in[1] = ang.x_axis_angle + 16'(e2r_pkg::QUARTER);
    assign ang_in[2] = ang.y_axis_angle;
    assign ang_in[3] = ang.y_axis_angle + 16'(e2r_pkg::QUARTER);
    assign ang_in[4] = ang.z_axis_angle;
    assign ang_in[5] = ang.z_axis_angle + 16'(e2r_pkg::QUARTER);

    for (genvar l = 0; l < 6; l++)
    begin : g_lane
        e2r_lane u_lane (
            .clk   (clk),
            .en    (en),
            .angle (ang_in[l]),
            .sine  (lane_out[l])
        );
    end

    e2r_merge u_merge (
        .clk (clk),
        .en  (en),
        .sx  (lane_out[0]),
        .cx  (lane_out[1]),
        .sy  (lane_out[2]),
        .cy  (lane_out[3]),
        .sz  (lane_out[4]),
        .cz  (lane_out[5]),
        .m   (m)
    );

    assign ang.ready = en[0];
    assign mat.valid = vld_reg[e2r_pkg::NSTAGE-1];
    assign mat.m00   = m[0];
    assign mat.m01   = m[1];
    assign mat.m02   = m[2];
    assign mat.m10   = m[3];
    assign mat.m11   = m[4];
    assign mat.m12   = m[5];
    assign mat.m20   = m[6];
    assign mat.m21   = m[7];
    assign mat.m22   = m[8];

    `E2R_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, !ang.ready,
        (&vld_reg) && !mat.ready)
    `E2R_ASSERT_NEXT(a_accept_enters, clk, rst_n, ang.valid && ang.ready, vld_reg[0])
    `E2R_ASSERT_IMPLY(a_diag_in_range, clk, rst_n, mat.valid,
        (mat.m00 <= 16'sd16384) && (mat.m00 >= -16'sd16384) &&
        (mat.m11 <= 16'sd16384) && (mat.m11 >= -16'sd16384) &&
        (mat.m22 <= 16'sd16384) && (mat.m22 >= -16'sd16384))
endmodule
`default_nettype wire

// ----- hw/rtl/e2r_lane.sv -----
`default_nettype none
// Sine of one binary angle: quadrant fold, then a five-term odd polynomial
// evaluated one Horner step per stage.
module e2r_lane (
    input  wire logic              clk,
    input  wire e2r_pkg::stage_en_t en,
    input  wire logic [15:0]       angle,
    output e2r_pkg::q14_t          sine
);
    logic [14:0] u0;
    logic [14:0] u_reg   [0:4];
    logic        neg_reg [0:4];
    logic [28:0] x2_reg  [0:3];
    logic [30:0] t_reg   [1:4];
    e2r_pkg::q14_t sine_reg;

    logic [46:0] fin;
    logic [16:0] mag;
    logic [15:0] capped;

    // odd quadrants run the quarter wave backwards
    always_comb
    begin
        if (angle[14])
        begin
            u0 = 15'(17'(e2r_pkg::QUARTER) - {3'b000, angle[13:0]});
        end
        else
        begin
            u0 = {1'b0, angle[13:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u_reg[0]   <= u0;
            neg_reg[0] <= angle[15];
            x2_reg[0]  <= 29'(30'(u0) * 30'(u0));
        end
    end

    for (genvar k = 1; k <= 4; k++)
    begin : g_horner
        logic [30:0] tin;
        logic [59:0] prod;
        if (k == 1)
        begin : g_first
            assign tin = e2r_pkg::K9;
        end
        else
        begin : g_rest
            assign tin = t_reg[k-1];
        end
        assign prod = 60'(tin) * 60'(x2_reg[k-1]);

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                t_reg[k]   <= 31'(32'(e2r_pkg::HORNER_C[k-1]) - prod[59:28]);
                u_reg[k]   <= u_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
        if (k <= 3)
        begin : g_x2
            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    x2_reg[k] <= x2_reg[k-1];
                end
            end
        end
    end

    assign fin = 47'(t_reg[4]) * 47'(u_reg[4]) + (47'd1 << 29);
    assign mag = fin[46:30];
    assign capped = (mag > 17'(e2r_pkg::QUARTER)) ? 16'(e2r_pkg::QUARTER) : mag[15:0];

    always_ff @(posedge clk)
    begin
        if (en[e2r_pkg::LANE_LAST])
        begin
            sine_reg <= neg_reg[4] ? -$signed(capped) : $signed(capped);
        end
    end

    assign sine = sine_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/e2r_merge.sv -----
`default_nettype none
// Rx*Ry in Q28, times Rz in Q42, then round half up and saturate.
module e2r_merge (
    input  wire logic               clk,
    input  wire e2r_pkg::stage_en_t en,
    input  wire e2r_pkg::q14_t      sx,
    input  wire e2r_pkg::q14_t      cx,
    input  wire e2r_pkg::q14_t      sy,
    input  wire e2r_pkg::q14_t      cy,
    input  wire e2r_pkg::q14_t      sz,
    input  wire e2r_pkg::q14_t      cz,
    output e2r_pkg::q14_t           m [9]
);
    localparam int SA = e2r_pkg::LANE_LAST + 1;

    logic signed [29:0] a_reg [3][3];
    e2r_pkg::q14_t      sz_reg;
    e2r_pkg::q14_t      cz_reg;
    logic signed [45:0] p_reg [3][5];
    e2r_pkg::q14_t      m_reg [9];

    function automatic logic signed [29:0] by_one(input e2r_pkg::q14_t v);
        by_one = 30'(v) <<< 14;
    endfunction

    function automatic e2r_pkg::q14_t round_sat(input logic signed [46:0] v);
        logic signed [46:0] r;
        r = (v + 47'sd134217728) >>> 28;
        if (r > 47'sd16384)
        begin
            round_sat = e2r_pkg::ONE_Q14;
        end
        else if (r < -47'sd16384)
        begin
            round_sat = -e2r_pkg::ONE_Q14;
        end
        else
        begin
            round_sat = r[15:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[SA])
        begin
            a_reg[0][0] <= by_one(cy);
            a_reg[0][1] <= '0;
            a_reg[0][2] <= -by_one(sy);
            a_reg[1][0] <= 30'(sx) * 30'(sy);
            a_reg[1][1] <= by_one(cx);
            a_reg[1][2] <= 30'(sx) * 30'(cy);
            a_reg[2][0] <= 30'(cx) * 30'(sy);
            a_reg[2][1] <= -by_one(sx);
            a_reg[2][2] <= 30'(cx) * 30'(cy);
            sz_reg      <= sz;
            cz_reg      <= cz;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            if (en[SA+1])
            begin
                p_reg[i][0] <= 46'(a_reg[i][0]) * 46'(cz_reg);
                p_reg[i][1] <= 46'(a_reg[i][1]) * 46'(sz_reg);
                p_reg[i][2] <= 46'(a_reg[i][0]) * 46'(sz_reg);
                p_reg[i][3] <= 46'(a_reg[i][1]) * 46'(cz_reg);
                p_reg[i][4] <= 46'(a_reg[i][2]) <<< 14;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[e2r_pkg::MERGE_LAST])
            begin
                m_reg[i*3]   <= round_sat(47'(p_reg[i][0]) - 47'(p_reg[i][1]));
                m_reg[i*3+1] <= round_sat(47'(p_reg[i][2]) + 47'(p_reg[i][3]));
                m_reg[i*3+2] <= round_sat(47'(p_reg[i][4]));
            end
        end
    end

    assign m = m_reg;
endmodule
`default_nettype wire
